// ----- design/ptat_pkg.sv -----
`default_nettype none

package ptat_pkg;

  localparam int TICK_W  = 48;
  localparam int DIV_W   = 16;
  localparam int SLOT_FW = 4;
  localparam int DUR_W   = 32;
  localparam int CMD_W   = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic KIND_WAKE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_SLEEP = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic               kind;
    logic [SLOT_FW-1:0] woken_slot;
    logic [TICK_W-1:0]  tick_value;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ----- design/ptat_if.sv -----
`default_nettype none

interface ptat_req_if;
  import ptat_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [SLOT_FW-1:0] slot;
  logic [DUR_W-1:0]   sleep_duration;

  modport source (output valid, output command, output slot, output sleep_duration,
                  input ready);
  modport sink (input valid, input command, input slot, input sleep_duration,
                output ready);
endinterface

interface ptat_rsp_if;
  import ptat_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [SLOT_FW-1:0] woken_slot;
  logic [TICK_W-1:0]  tick_value;
  logic               last;

  modport source (output valid, output kind, output woken_slot, output tick_value,
                  output last, input ready);
  modport sink (input valid, input kind, input woken_slot, input tick_value,
                input last, output ready);
endinterface

interface ptat_cfg_if;
  import ptat_pkg::*;
  logic             valid;
  logic             ready;
  logic [DIV_W-1:0] prescale_divide;

  modport source (output valid, output prescale_divide, input ready);
  modport sink (input valid, input prescale_divide, output ready);
endinterface

`default_nettype wire

// ----- design/ptat_deadline_mem.sv -----
`default_nettype none

module ptat_deadline_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ptat_pkg::TICK_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ptat_pkg::TICK_W-1:0] rd_data
);
  import ptat_pkg::*;

  logic [TICK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/ptat_out_fifo.sv -----
`default_nettype none

module ptat_out_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ptat_pkg::result_t push_data,
  output logic              full,
  ptat_rsp_if.source        rsp
);
  import ptat_pkg::*;

  result_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       pop;

  assign pop  = rsp.valid && rsp.ready;
  assign full = (cnt == 2'd2);

  assign rsp.valid      = (cnt != 2'd0);
  assign rsp.kind       = entry[rd_ptr].kind;
  assign rsp.woken_slot = entry[rd_ptr].woken_slot;
  assign rsp.tick_value = entry[rd_ptr].tick_value;
  assign rsp.last       = entry[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/prescaled_tick_alarm_table_core.sv -----
// results: a read word can be taken the cycle after its request is taken; after a counted
// tick the deadlines are read from memory and compared in turn, a hit is held, and it is
// queued when the next hit arrives or, for a lone or last one, in the flush state
// throughput: one item per cycle for sleep, read and non-counting ticks while the output
// queue has room; a counted tick holds ready low through the scan and flush, set by the
// one-read-per-cycle scan of the deadline memory, longer if the result side stalls
// reset: synchronous, clears counters, armed flags and queue; divide returns to 1
`default_nettype none

module prescaled_tick_alarm_table_core #(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ptat_cfg_if.sink   cfg,
  ptat_req_if.sink   req,
  ptat_rsp_if.source rsp
);
  import ptat_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  state_t            state;
  state_t            state_next;
  logic [DIV_W-1:0]  divide;
  logic [DIV_W-1:0]  prescale_count;
  logic [TICK_W-1:0] tick_count;
  logic [SLOTS-1:0]  armed;
  logic [CNT_W-1:0]  scan_idx;
  logic              cmp_vld;
  logic [IDX_W-1:0]  cmp_idx;
  logic              held_vld;
  logic [IDX_W-1:0]  held_idx;

  logic              accept;
  cmd_t              cmd;
  logic [DIV_W-1:0]  pc_inc;
  logic [DIV_W-1:0]  divide_eff;
  logic              tick_hit;
  logic [TICK_W:0]   sum;
  logic [TICK_W-1:0] deadline;
  logic [6:0]        slot_ext;
  logic              slot_ok;
  logic [IDX_W-1:0]  slot_addr;
  logic              mem_wr;
  logic              rd_en;
  logic [TICK_W-1:0] rd_data;
  logic              hit;
  logic              scan_go;
  logic              scan_done;
  logic              fifo_full;
  logic              push;
  result_t           push_data;
  logic [6:0]        held_ext;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE) && !fifo_full;
  assign accept    = req.valid && req.ready;
  assign cmd       = cmd_t'(req.command);

  assign pc_inc     = prescale_count + DIV_W'(1);
  assign divide_eff = (divide == '0) ? DIV_W'(1) : divide;
  assign tick_hit   = (pc_inc == '0) || (pc_inc >= divide_eff);

  assign sum      = {1'b0, tick_count} + (TICK_W + 1)'(req.sleep_duration);
  assign deadline = sum[TICK_W] ? TICK_MAX : sum[TICK_W-1:0];

  assign slot_ext  = {3'b000, req.slot};
  assign slot_ok   = slot_ext < 7'(SLOTS);
  assign slot_addr = slot_ext[IDX_W-1:0];
  assign mem_wr    = accept && (cmd == CMD_SLEEP) && slot_ok;

  assign held_ext  = 7'(held_idx);
  assign scan_done = (scan_idx == CNT_W'(SLOTS));

  assign hit     = (state == ST_SCAN) && cmp_vld && armed[cmp_idx] &&
                   (rd_data <= tick_count);
  assign scan_go = (state == ST_SCAN) && !(hit && held_vld && fifo_full);

  ptat_deadline_mem #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr),
    .wr_addr (slot_addr),
    .wr_data (deadline),
    .rd_en   (rd_en),
    .rd_addr (scan_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  ptat_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (fifo_full),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    push       = 1'b0;
    push_data  = '{kind: KIND_WAKE, woken_slot: held_ext[SLOT_FW-1:0],
                   tick_value: tick_count, last: 1'b0};
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_TICK: begin
              if (tick_hit) begin
                state_next = ST_SCAN;
              end
            end
            CMD_READ: begin
              push      = 1'b1;
              push_data = '{kind: KIND_READ, woken_slot: '0,
                            tick_value: tick_count, last: 1'b1};
            end
            CMD_SLEEP, CMD_NONE: begin
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_go) begin
          rd_en = !scan_done;
          push  = hit && held_vld;
          if (scan_done && !cmp_vld) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!held_vld) begin
          state_next = ST_IDLE;
        end else if (!fifo_full) begin
          push           = 1'b1;
          push_data.last = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      divide         <= DIV_W'(1);
      prescale_count <= '0;
      tick_count     <= '0;
      armed          <= '0;
      scan_idx       <= '0;
      cmp_vld        <= 1'b0;
      held_vld       <= 1'b0;
      cmp_idx        <= '0;
      held_idx       <= '0;
    end else begin
      if (cfg.valid) begin
        divide <= cfg.prescale_divide;
      end
      if (accept && (cmd == CMD_TICK)) begin
        prescale_count <= tick_hit ? '0 : pc_inc;
        if (tick_hit) begin
          tick_count <= tick_count + TICK_W'(1);
        end
        scan_idx <= '0;
        cmp_vld  <= 1'b0;
        held_vld <= 1'b0;
      end
      if (mem_wr) begin
        armed[slot_addr] <= 1'b1;
      end
      if (scan_go) begin
        if (rd_en) begin
          cmp_vld  <= 1'b1;
          cmp_idx  <= scan_idx[IDX_W-1:0];
          scan_idx <= scan_idx + CNT_W'(1);
        end else begin
          cmp_vld <= 1'b0;
        end
        if (hit) begin
          armed[cmp_idx] <= 1'b0;
          held_idx       <= cmp_idx;
          held_vld       <= 1'b1;
        end
      end
      if ((state == ST_FLUSH) && push) begin
        held_vld <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- verif/alarm_checker.sv -----
module alarm_checker #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  ptat_cfg_if  cfg,
  ptat_req_if  req,
  ptat_rsp_if  rsp,
  output int   errors,
  output int   words_owed,
  output int   requests_seen,
  output int   wakes_seen,
  output int   reads_seen
);
  import ptat_pkg::*;

  logic [TICK_W-1:0] count_now;
  logic [DIV_W-1:0]  prescaler;
  logic [DIV_W-1:0]  divide;
  logic [SLOTS-1:0]  armed;
  logic [TICK_W-1:0] deadline [SLOTS];
  result_t           owed_words [$];
  int                mismatch_count;
  int                request_count;
  int                wake_count;
  int                read_count;

  task automatic advance_tick();
    logic [DIV_W-1:0] eff;
    logic [SLOTS-1:0] hit;
    result_t          r;
    eff = (divide == '0) ? DIV_W'(1) : divide;
    prescaler = prescaler + 1'b1;
    if (prescaler < eff && prescaler != '0) return;
    prescaler = '0;
    count_now = count_now + 1'b1;
    hit = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (armed[i] && deadline[i] <= count_now) hit[i] = 1'b1;
    end
    armed = armed & ~hit;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit[i]) begin
        r.kind       = KIND_WAKE;
        r.woken_slot = SLOT_FW'(i);
        r.tick_value = count_now;
        r.last       = ((hit >> (i + 1)) == '0);
        owed_words.push_back(r);
      end
    end
  endtask

  task automatic arm_slot(input logic [SLOT_FW-1:0] s, input logic [DUR_W-1:0] dur);
    logic [TICK_W:0] sum;
    if (int'(s) >= SLOTS) return;
    sum = {1'b0, count_now} + (TICK_W + 1)'(dur);
    deadline[s] = (sum > {1'b0, TICK_MAX}) ? TICK_MAX : sum[TICK_W-1:0];
    armed[s] = 1'b1;
  endtask

  task automatic apply_request(input cmd_t cmd, input logic [SLOT_FW-1:0] s,
                               input logic [DUR_W-1:0] dur);
    result_t r;
    case (cmd)
      CMD_TICK: begin
        advance_tick();
      end
      CMD_SLEEP: begin
        arm_slot(s, dur);
      end
      CMD_READ: begin
        r.kind       = KIND_READ;
        r.woken_slot = '0;
        r.tick_value = count_now;
        r.last       = 1'b1;
        owed_words.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_word();
    result_t want;
    if (rsp.kind == KIND_WAKE) wake_count++;
    else read_count++;
    if (owed_words.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("mismatch: unexpected word kind=%0d slot=%0d tick=%0h last=%0d",
                 rsp.kind, rsp.woken_slot, rsp.tick_value, rsp.last);
      return;
    end
    want = owed_words.pop_front();
    if (rsp.kind !== want.kind || rsp.woken_slot !== want.woken_slot ||
        rsp.tick_value !== want.tick_value || rsp.last !== want.last) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display(
          "mismatch: want kind=%0d slot=%0d tick=%0h last=%0d, got %0d %0d %0h %0d",
          want.kind, want.woken_slot, want.tick_value, want.last,
          rsp.kind, rsp.woken_slot, rsp.tick_value, rsp.last);
    end
  endtask

  initial begin
    mismatch_count = 0;
    request_count  = 0;
    wake_count     = 0;
    read_count     = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      count_now = '0;
      prescaler = '0;
      divide    = DIV_W'(1);
      armed     = '0;
      owed_words.delete();
    end else begin
      if (cfg.valid && cfg.ready) divide = cfg.prescale_divide;
      if (req.valid && req.ready) begin
        request_count++;
        apply_request(cmd_t'(req.command), req.slot, req.sleep_duration);
      end
      if (rsp.valid && rsp.ready) check_word();
    end
    errors        <= mismatch_count;
    words_owed    <= owed_words.size();
    requests_seen <= request_count;
    wakes_seen    <= wake_count;
    reads_seen    <= read_count;
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import ptat_pkg::*;

  localparam int SLOTS       = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  int   send_idle;
  int   recv_idle;
  int   cycle_count;
  int   divide_writes;
  int   errors;
  int   words_owed;
  int   requests_seen;
  int   wakes_seen;
  int   reads_seen;

  ptat_cfg_if cfg_ch ();
  ptat_req_if req_ch ();
  ptat_rsp_if rsp_ch ();

  prescaled_tick_alarm_table_core #(.SLOTS(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alarm_checker #(.SLOTS(SLOTS)) checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .req           (req_ch),
    .rsp           (rsp_ch),
    .errors        (errors),
    .words_owed    (words_owed),
    .requests_seen (requests_seen),
    .wakes_seen    (wakes_seen),
    .reads_seen    (reads_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic put_word(input cmd_t cmd, input logic [SLOT_FW-1:0] s,
                          input logic [DUR_W-1:0] dur);
    while ($urandom_range(0, 99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.command        <= cmd;
    req_ch.slot           <= s;
    req_ch.sleep_duration <= dur;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // drain all owed words, then let a silent scan finish
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
  endtask

  task automatic set_divide(input logic [DIV_W-1:0] value);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.prescale_divide <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    divide_writes++;
  endtask

  task automatic random_word();
    int                  pick;
    int                  span;
    logic [DUR_W-1:0]    dur;
    logic [SLOT_FW-1:0]  s;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 9);
    s    = SLOT_FW'($urandom_range(0, 15));
    if (span < 7) dur = $urandom_range(0, 6);
    else if (span < 9) dur = $urandom_range(0, 40);
    else dur = $urandom();
    if (pick < 45) put_word(CMD_TICK, s, $urandom());
    else if (pick < 80) put_word(CMD_SLEEP, s, dur);
    else if (pick < 97) put_word(CMD_READ, s, $urandom());
    else put_word(CMD_NONE, s, $urandom());
  endtask

  initial begin
    divide_writes          = 0;
    send_idle              = 9;
    recv_idle              = 46;
    rst                   <= 1'b1;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.prescale_divide <= '0;
    req_ch.valid          <= 1'b0;
    req_ch.command        <= CMD_NONE;
    req_ch.slot           <= '0;
    req_ch.sleep_duration <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_divide(16'd1);
    put_word(CMD_READ, 4'd0, '0);
    put_word(CMD_TICK, 4'd0, '0);
    put_word(CMD_SLEEP, 4'd0, '0);
    put_word(CMD_SLEEP, 4'd15, '1);
    put_word(CMD_SLEEP, 4'd5, 32'd1);
    put_word(CMD_SLEEP, 4'd5, 32'd3);
    put_word(CMD_NONE, 4'hF, '1);
    put_word(CMD_TICK, 4'hF, '1);
    put_word(CMD_TICK, 4'd0, '0);
    put_word(CMD_TICK, 4'd0, '0);
    put_word(CMD_READ, 4'd0, '0);
    for (int i = 0; i < SLOTS; i++) put_word(CMD_SLEEP, SLOT_FW'(i), '0);
    put_word(CMD_TICK, 4'd0, '0);
    settle();

    // divide of zero counts every raw tick
    set_divide(16'd0);
    put_word(CMD_SLEEP, 4'd3, 32'd1);
    put_word(CMD_TICK, 4'd0, '0);
    put_word(CMD_READ, 4'd0, '0);
    settle();

    // lower the divide below the prescaler
    set_divide(16'hFFFF);
    put_word(CMD_SLEEP, 4'd9, '0);
    repeat (3) put_word(CMD_TICK, 4'd0, '0);
    settle();
    set_divide(16'd2);
    put_word(CMD_TICK, 4'd0, '0);
    put_word(CMD_READ, 4'd0, '0);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      send_idle = (mode == 0) ? 9 : (mode == 1) ? 46 : 0;
      recv_idle = (mode == 0) ? 46 : (mode == 1) ? 9 : 0;
      for (int part = 0; part < 2; part++) begin
        if (mode == 0 && part == 0) set_divide(16'd1);
        else if (mode == 2 && part == 1) set_divide(DIV_W'($urandom_range(0, 65535)));
        else set_divide(DIV_W'($urandom_range(1, 4)));
        for (int n = 0; n < 52; n++) begin
          random_word();
          if (n == 30 && part == 0) settle();
        end
        settle();
      end
    end

    settle();
    $display("run covered %0d requests, %0d wake words, %0d count reads",
             requests_seen, wakes_seen, reads_seen);
    $display("across %0d divide settings and three handshake pacing modes", divide_writes);
    if (errors == 0 && words_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
